### hdl/csc_pkg.sv
package csc_pkg;

  localparam int QF       = 30;
  localparam int FRAC_OUT = 16;
  localparam int NUM_W    = 47;
  localparam int DEN_W    = 16;
  localparam int Q_W      = 31;
  localparam int G_W      = 40;
  localparam int C_MAX    = 99;

  localparam longint unsigned ONE_Q   = 64'd1 << QF;
  localparam longint unsigned Y_EDGE  = ((64'd31 << QF) + 64'd500) / 64'd1000;
  localparam longint unsigned Y_TOP   = ONE_Q - Y_EDGE;
  localparam longint unsigned TH_LO   = ((64'd3 << QF) + 64'd50) / 64'd100;
  localparam longint unsigned TH_HI   = ((64'd97 << QF) + 64'd50) / 64'd100;
  localparam longint unsigned Y_HIGHC = ((64'd969 << QF) + 64'd500) / 64'd1000;

  typedef logic [G_W-1:0] g_tab_t [C_MAX+1];
  typedef logic [29:0] y_tab_t [C_MAX+1];

  typedef struct packed {
    logic [1:0]     k;
    logic [G_W-1:0] g;
    logic [29:0]    y_lo;
    logic [29:0]    y_hi;
  } csc_side_t;

  // rounded quotient by shift and subtract, for table building
  function automatic longint unsigned div_round(input longint unsigned n,
                                                input longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    n = n + (d >> 1);
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // second derivative term for the outer (mid = 0) or middle (mid = 1) interval
  function automatic g_tab_t make_g_tab(input logic mid);
    g_tab_t tab;
    longint unsigned n6, dn, h, num, dd;
    for (int c = 0; c <= C_MAX; c++) begin
      n6  = (100 + c) * (1000 + 10 * c) + (100 - c) * 10 * c - 876 * (100 - c);
      dn  = (100 - c) * (1000 + 10 * c);
      h   = mid ? (200 - 2 * c) : (100 + c);
      num = n6 * h * h * (64'd1 << (QF - 8));
      dd  = dn * 625;
      tab[c] = G_W'(div_round(num, dd));
    end
    return tab;
  endfunction

  function automatic y_tab_t make_y_tab(input logic upper);
    y_tab_t tab;
    longint unsigned n;
    for (int c = 0; c <= C_MAX; c++) begin
      n = upper ? (300 + c) : (100 - c);
      tab[c] = 30'(((n << QF) + 64'd200) / 64'd400);
    end
    return tab;
  endfunction

  localparam g_tab_t G_OUTER = make_g_tab(1'b0);
  localparam g_tab_t G_MID   = make_g_tab(1'b1);
  localparam y_tab_t Y_LOW   = make_y_tab(1'b0);
  localparam y_tab_t Y_UP    = make_y_tab(1'b1);

  // q30 product of two nonnegative values at most one, rounded half up
  function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'd1 << (QF - 1));
    return p[60:30];
  endfunction

endpackage

### hdl/csc_div.sv
module csc_div import csc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  csc_side_t        side_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output csc_side_t        side_o
);

  logic             v_q    [Q_W];
  logic [DEN_W-1:0] rem_q  [Q_W];
  logic [NUM_W-1:0] num_q  [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W];
  logic [Q_W-1:0]   quo_q  [Q_W];
  csc_side_t        side_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic             v_p;
    logic [DEN_W-1:0] rem_p;
    logic [NUM_W-1:0] num_p;
    logic [DEN_W-1:0] den_p;
    logic [Q_W-1:0]   quo_p;
    csc_side_t        side_p;
    logic [DEN_W:0]   cat;
    logic             ge;
    logic [DEN_W:0]   diff;

    if (s == 0) begin : g_first
      assign v_p    = valid_i;
      assign rem_p  = num_i[NUM_W-1:Q_W];
      assign num_p  = num_i;
      assign den_p  = den_i;
      assign quo_p  = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign num_p  = num_q[s-1];
      assign den_p  = den_q[s-1];
      assign quo_p  = quo_q[s-1];
      assign side_p = side_q[s-1];
    end

    assign cat  = {rem_p, num_p[Q_W-1-s]};
    assign ge   = cat >= {1'b0, den_p};
    assign diff = cat - {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
      num_q[s]  <= num_p;
      den_q[s]  <= den_p;
      quo_q[s]  <= quo_p | (Q_W'(ge) << (Q_W - 1 - s));
      side_q[s] <= side_p;
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

### hdl/contrast_spline_curve.sv
// Contrast tone curve: one curve entry per transaction. Set contrast_level_i with
// contrast_level_we_i while idle (values above 99 act as 99). Pulse start with
// curve_index_i; busy is always low, so an index may enter on every cycle. Each
// result shows on curve_value_o for one cycle with curve_valid_o high, in start
// order. Each start passes an input register, the 31-stage bit-per-stage divider
// that forms the interval weight, and then the multiply, sum and clamp stages.
// The receiver cannot stall the results.
module contrast_spline_curve import csc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        contrast_level_we_i,
  input  logic [6:0]  contrast_level_i,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  curve_index_i,
  output logic        curve_valid_o,
  output logic [15:0] curve_value_o
);

  logic [6:0] contrast_q;
  logic       in_v_q;
  logic [7:0] idx_q;
  logic [6:0] c_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q <= '0;
      in_v_q     <= 1'b0;
    end else begin
      if (contrast_level_we_i) begin
        contrast_q <= contrast_level_i;
      end
      in_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= curve_index_i;
    c_q   <= (contrast_q > 7'(C_MAX)) ? 7'(C_MAX) : contrast_q;
  end

  // interval select and divider operands
  logic [16:0]      pos;
  logic [16:0]      x1_n, x2_n, lo_n;
  logic [7:0]       h400;
  logic [16:0]      t;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  csc_side_t        side;

  always_comb begin
    pos  = 17'(idx_q) * 17'd400;
    x1_n = (17'd100 + 17'(c_q)) * 17'd255;
    x2_n = (17'd300 - 17'(c_q)) * 17'd255;
    if (pos < x1_n) begin
      side.k    = 2'd0;
      lo_n      = '0;
      h400      = 8'(8'd100 + 8'(c_q));
      side.g    = G_OUTER[c_q];
      side.y_lo = 30'(Y_EDGE);
      side.y_hi = Y_LOW[c_q];
    end else if (pos < x2_n) begin
      side.k    = 2'd1;
      lo_n      = x1_n;
      h400      = 8'(8'd200 - 8'(c_q) - 8'(c_q));
      side.g    = G_MID[c_q];
      side.y_lo = Y_LOW[c_q];
      side.y_hi = Y_UP[c_q];
    end else begin
      side.k    = 2'd2;
      lo_n      = x2_n;
      h400      = 8'(8'd100 + 8'(c_q));
      side.g    = G_OUTER[c_q];
      side.y_lo = Y_UP[c_q];
      side.y_hi = 30'(Y_TOP);
    end
    t   = pos - lo_n;
    den = DEN_W'(16'(h400) * 16'd255);
    num = (NUM_W'(t) << QF) + NUM_W'(den >> 1);
  end

  logic           dv;
  logic [Q_W-1:0] b_w;
  csc_side_t      ds;

  csc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v_q),
    .num_i   (num),
    .den_i   (den),
    .side_i  (side),
    .valid_o (dv),
    .quo_o   (b_w),
    .side_o  (ds)
  );

  logic [Q_W-1:0] a_w;
  assign a_w = Q_W'(ONE_Q) - b_w;

  logic [6:0]     v_q;
  logic [Q_W-1:0] a1_q, b1_q, aa_q, bb_q, ay1_q, by1_q;
  logic [1:0]     k1_q, k2_q, k3_q, k4_q, k5_q;
  logic [G_W-1:0] g1_q, g2_q, g3_q;
  logic [Q_W-1:0] a2_q, b2_q, aaa_q, bbb_q, ay2_q, by2_q;
  logic [Q_W-1:0] cua_q, cub_q, ay3_q, by3_q;
  logic [60:0]    pla_q, plb_q;
  logic [40:0]    pha_q, phb_q;
  logic [Q_W-1:0] ay4_q, by4_q;
  logic [41:0]    ra_q, rb_q;
  logic [Q_W-1:0] ay5_q, by5_q;
  logic signed [43:0] s_q;
  logic [15:0]    out_q;

  logic signed [43:0] s_d;
  logic signed [43:0] sc;
  logic [43:0]        rnd;

  always_comb begin
    s_d = 44'(ay5_q) + 44'(by5_q);
    case (k5_q)
      2'd0:    s_d = s_d - 44'(rb_q);
      2'd1:    s_d = s_d - 44'(ra_q) + 44'(rb_q);
      2'd2:    s_d = s_d + 44'(ra_q);
      default: s_d = s_d;
    endcase
    sc = s_q;
    if (s_q < $signed(44'(TH_LO))) begin
      sc = 44'(Y_EDGE);
    end
    if (s_q > $signed(44'(TH_HI))) begin
      sc = 44'(Y_HIGHC);
    end
    rnd = 44'(sc) + (44'd1 << (QF - FRAC_OUT - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], dv};
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q  <= a_w;
    b1_q  <= b_w;
    aa_q  <= mulq(a_w, a_w);
    bb_q  <= mulq(b_w, b_w);
    ay1_q <= mulq(a_w, Q_W'(ds.y_lo));
    by1_q <= mulq(b_w, Q_W'(ds.y_hi));
    k1_q  <= ds.k;
    g1_q  <= ds.g;

    a2_q  <= a1_q;
    b2_q  <= b1_q;
    aaa_q <= mulq(aa_q, a1_q);
    bbb_q <= mulq(bb_q, b1_q);
    ay2_q <= ay1_q;
    by2_q <= by1_q;
    k2_q  <= k1_q;
    g2_q  <= g1_q;

    cua_q <= a2_q - aaa_q;
    cub_q <= b2_q - bbb_q;
    ay3_q <= ay2_q;
    by3_q <= by2_q;
    k3_q  <= k2_q;
    g3_q  <= g2_q;

    pla_q <= 61'(cua_q) * 61'(g3_q[29:0]);
    plb_q <= 61'(cub_q) * 61'(g3_q[29:0]);
    pha_q <= 41'(cua_q) * 41'(g3_q[G_W-1:30]);
    phb_q <= 41'(cub_q) * 41'(g3_q[G_W-1:30]);
    ay4_q <= ay3_q;
    by4_q <= by3_q;
    k4_q  <= k3_q;

    ra_q  <= 42'(pha_q) + 42'((pla_q + (61'd1 << (QF - 1))) >> QF);
    rb_q  <= 42'(phb_q) + 42'((plb_q + (61'd1 << (QF - 1))) >> QF);
    ay5_q <= ay4_q;
    by5_q <= by4_q;
    k5_q  <= k4_q;

    s_q   <= s_d;

    out_q <= rnd[QF-FRAC_OUT+15:QF-FRAC_OUT];
  end

  assign curve_valid_o = v_q[6];
  assign curve_value_o = out_q;

endmodule
